### hdl/ots_pkg.sv
// Shared types, constants and codes for the one-shot timer table.
package ots_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = 6;
    localparam int ID_W  = 64;
    localparam int TIME_W = 64;
    localparam int TAG_W = 32;

    localparam logic [1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [1:0] KIND_CANCEL   = 2'd1;
    localparam logic [1:0] KIND_RUN      = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_INVALID   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] due_time;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   cancel_id;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  timer_id;
        logic [TAG_W-1:0] fired_tag;
        logic             is_expiry;
        logic [CNT_W-1:0] fired_count;
        logic [CNT_W-1:0] pending_count;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

### hdl/ots_if.sv
// Valid/ready channel interfaces for items and results of the timer table.
interface ots_item_if;
    logic          valid;
    logic          ready;
    ots_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ots_result_if;
    logic            valid;
    logic            ready;
    ots_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/one_shot_timer_table.sv
// One-shot timer table: valid bits in flops, timer entries in a synchronous memory.
// A schedule or an invalid request is taken in ST_IDLE, and ST_EXEC writes its result
// to the output register. A cancel or a run walks the entry memory one slot per cycle
// while no result waits for the output register to drain; the scan is sequential since
// the entry memory has a single read port. A new item is taken once the previous one has
// produced its last result, while that result may still sit in the output register. The
// lowest free slot for a schedule comes from a priority encoder over the valid bits.
module one_shot_timer_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ots_item_if.sink         i_in,
    ots_result_if.source     o_out
);
    import ots_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_CLOSE = 2'd3;

    logic [1:0]       r_state, n_state;
    t_item            r_item, n_item;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_fired, n_fired;
    logic [IDX_W-1:0] r_idx, n_idx;

    t_entry           r_slot_mem [SLOTS];
    t_entry           r_rd_data;
    logic             mem_we;
    t_entry           mem_wdata;

    logic             r_out_valid;
    t_result          r_out;
    logic             out_free;
    logic             emit;
    t_result          emit_res;

    logic             any_free;
    logic [IDX_W-1:0] free_idx;
    logic             hit;
    logic             last_slot;

    // No transfer is taken while reset is held.
    assign i_in.ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign out_free    = !r_out_valid || o_out.ready;

    // Lowest free slot.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign last_slot = (r_idx == IDX_W'(SLOTS - 1));

    always_comb begin
        if (r_item.kind == KIND_CANCEL) begin
            hit = r_valid[r_idx] && (r_rd_data.id == r_item.cancel_id);
        end else begin
            hit = r_valid[r_idx] && (r_rd_data.due <= r_item.now);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_valid   = r_valid;
        n_next_id = r_next_id;
        n_count   = r_count;
        n_fired   = r_fired;
        n_idx     = r_idx;
        mem_we    = 1'b0;
        mem_wdata.id  = r_next_id;
        mem_wdata.due = r_item.due_time;
        mem_wdata.tag = r_item.tag;
        emit      = 1'b0;
        emit_res  = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_item  = i_in.data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_item.kind)
                    KIND_SCHEDULE: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (any_free) begin
                                mem_we            = 1'b1;
                                n_valid[free_idx] = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_next_id         = r_next_id + 1'b1;
                                emit_res.status   = STATUS_OK;
                                emit_res.timer_id = r_next_id;
                            end else begin
                                emit_res.status   = STATUS_FULL;
                            end
                            emit_res.pending_count = n_count;
                            emit_res.last          = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_CANCEL, KIND_RUN: begin
                        if (r_item.kind == KIND_CANCEL && r_item.cancel_id == '0) begin
                            if (out_free) begin
                                emit                   = 1'b1;
                                emit_res.status        = STATUS_INVALID;
                                emit_res.pending_count = r_count;
                                emit_res.last          = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_idx   = '0;
                            n_fired = '0;
                            n_state = ST_SCAN;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit                   = 1'b1;
                            emit_res.status        = STATUS_INVALID;
                            emit_res.pending_count = r_count;
                            emit_res.last          = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                // The read data always belongs to the slot at r_idx.
                if (hit) begin
                    if (out_free) begin
                        emit             = 1'b1;
                        n_valid[r_idx]   = 1'b0;
                        n_count          = r_count - 1'b1;
                        emit_res.status  = STATUS_OK;
                        emit_res.pending_count = n_count;
                        if (r_item.kind == KIND_CANCEL) begin
                            emit_res.last = 1'b1;
                            n_state       = ST_IDLE;
                        end else begin
                            emit_res.timer_id  = r_rd_data.id;
                            emit_res.fired_tag = r_rd_data.tag;
                            emit_res.is_expiry = 1'b1;
                            n_fired = r_fired + 1'b1;
                            if (last_slot) begin
                                n_state = ST_CLOSE;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end
                end else if (last_slot) begin
                    if (out_free) begin
                        emit                   = 1'b1;
                        emit_res.pending_count = r_count;
                        emit_res.last          = 1'b1;
                        if (r_item.kind == KIND_CANCEL) begin
                            emit_res.status = STATUS_NOT_FOUND;
                        end else begin
                            emit_res.status      = STATUS_OK;
                            emit_res.fired_count = r_fired;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    emit_res.status        = STATUS_OK;
                    emit_res.fired_count   = r_fired;
                    emit_res.pending_count = r_count;
                    emit_res.last          = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port addressed by the next index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[free_idx] <= mem_wdata;
        end
        r_rd_data <= r_slot_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_next_id <= ID_W'(1);
            r_count   <= '0;
            r_fired   <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_next_id <= n_next_id;
            r_count   <= n_count;
            r_fired   <= n_fired;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (emit) begin
            r_out <= emit_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
